// ===== rtl/core/adq_pkg.sv =====
// Shared types and constants for the array double-ended queue.
// Used by the controller, the datapath and the top level; no dependencies.
package adq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;
   localparam int CAP_W         = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_PUSH_HEAD = 2'd0,
      OP_POP_HEAD  = 2'd1,
      OP_PUSH_TAIL = 2'd2,
      OP_POP_TAIL  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_NO_TAIL = 3'd2,
      ST_NO_HEAD = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // execute the operation on the request ports
      logic load_out;  // move the pending result into the output register
   } cmd_type;

   // Queue condition reported back by the datapath.
   typedef struct packed {
      logic empty;
      logic full;
   } stat_type;

endpackage

// ===== rtl/core/adq_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module adq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/adq_datapath.sv =====
// Datapath of the double-ended queue: head/tail indices, capacity register,
// slot RAM and result registers. Depends on adq_pkg and adq_ram.
module adq_datapath
   import adq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic                     cfg_write,
   input  logic [CAP_W-1:0]         cfg_capacity,
   input  logic [1:0]               op_code,
   input  logic signed [DATA_W-1:0] op_data,
   output logic [2:0]               res_status,
   output logic signed [DATA_W-1:0] res_data,
   output logic                     res_empty,
   output logic                     res_full
);

   // Indices are held offset by one so that the "unused" marker is zero.
   localparam int IW = $clog2(DEPTH + 2);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = (IW > CAP_W) ? IW : CAP_W;

   logic [IW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CAP_W-1:0] cap_ff;
   logic [CW-1:0]    cap_wide;
   logic [IW-1:0]    eff_cap;

   status_type       pend_status_ff, pend_status_in;
   logic             pend_pop_ff, pend_pop_in;
   logic             pend_empty_ff, pend_empty_in;
   logic             pend_full_ff, pend_full_in;

   logic [2:0]        out_status_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic              out_empty_ff, out_full_ff;

   logic              ram_wr, ram_rd;
   logic [IW-1:0]     ram_idx;
   logic [DATA_W-1:0] ram_rdata;
   logic              cur_empty, cur_full;

   function automatic logic q_empty(input logic [IW-1:0] h, input logic [IW-1:0] t);
      return ((h == '0) && (t == '0)) || (h > t);
   endfunction

   function automatic logic q_full(input logic [IW-1:0] h, input logic [IW-1:0] t,
                                   input logic [IW-1:0] cap);
      return (h == IW'(1)) && (t >= cap);
   endfunction

   always_comb begin
      cap_wide = CW'(cap_ff);
      if (cap_wide == '0) begin
         eff_cap = IW'(1);
      end else if (cap_wide > CW'(DEPTH)) begin
         eff_cap = IW'(DEPTH);
      end else begin
         eff_cap = cap_wide[IW-1:0];
      end
   end

   assign cur_empty = q_empty(head_ff, tail_ff);
   assign cur_full  = q_full(head_ff, tail_ff, eff_cap);

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      pend_status_in = ST_OK;
      pend_pop_in    = 1'b0;
      ram_wr         = 1'b0;
      ram_rd         = 1'b0;
      ram_idx        = '0;
      unique case (opcode_type'(op_code))
         OP_PUSH_HEAD: begin
            if (cur_full) begin
               pend_status_in = ST_FULL;
            end else if (head_ff == '0) begin
               // first item of all goes to slot zero
               head_in = IW'(1);
               tail_in = tail_ff + IW'(1);
               ram_wr  = 1'b1;
               ram_idx = tail_ff;
            end else if (head_ff != IW'(1)) begin
               head_in = head_ff - IW'(1);
               ram_wr  = 1'b1;
               ram_idx = head_ff - IW'(2);
            end else begin
               pend_status_in = ST_NO_HEAD;
            end
         end
         OP_POP_HEAD: begin
            if (cur_empty) begin
               pend_status_in = ST_EMPTY;
            end else begin
               head_in     = head_ff + IW'(1);
               ram_rd      = 1'b1;
               ram_idx     = head_ff - IW'(1);
               pend_pop_in = 1'b1;
            end
         end
         OP_PUSH_TAIL: begin
            if (cur_full) begin
               pend_status_in = ST_FULL;
            end else if (tail_ff >= eff_cap) begin
               pend_status_in = ST_NO_TAIL;
            end else begin
               if (head_ff == '0) begin
                  head_in = IW'(1);
               end
               tail_in = tail_ff + IW'(1);
               ram_wr  = 1'b1;
               ram_idx = tail_ff;
            end
         end
         OP_POP_TAIL: begin
            if (cur_empty) begin
               pend_status_in = ST_EMPTY;
            end else begin
               tail_in     = tail_ff - IW'(1);
               ram_rd      = 1'b1;
               ram_idx     = tail_ff - IW'(1);
               pend_pop_in = 1'b1;
            end
         end
         default: begin
            pend_status_in = ST_OK;
         end
      endcase
      pend_empty_in = q_empty(head_in, tail_in);
      pend_full_in  = q_full(head_in, tail_in, eff_cap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cap_ff  <= CAP_RESET;
      end else begin
         if (cmd.accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
         if (cfg_write) begin
            cap_ff <= cfg_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_status_ff <= pend_status_in;
         pend_pop_ff    <= pend_pop_in;
         pend_empty_ff  <= pend_empty_in;
         pend_full_ff   <= pend_full_in;
      end
      if (cmd.load_out) begin
         out_status_ff <= pend_status_ff;
         out_data_ff   <= pend_pop_ff ? ram_rdata : '0;
         out_empty_ff  <= pend_empty_ff;
         out_full_ff   <= pend_full_ff;
      end
   end

   adq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (cmd.accept & ram_wr),
      .rd_en   (cmd.accept & ram_rd),
      .addr    (ram_idx[AW-1:0]),
      .wr_data (op_data),
      .rd_data (ram_rdata)
   );

   assign stat.empty = cur_empty;
   assign stat.full  = cur_full;

   assign res_status = out_status_ff;
   assign res_data   = out_data_ff;
   assign res_empty  = out_empty_ff;
   assign res_full   = out_full_ff;

endmodule

// ===== rtl/core/adq_ctrl.sv =====
// Controller of the double-ended queue: request handshake, sequencing of
// one operation at a time and the result valid flag. Depends on adq_pkg.
module adq_ctrl
   import adq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output logic     csr_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign cmd.accept   = (state_ff == S_IDLE) && req_valid;
   assign cmd.load_out = ((state_ff == S_EXEC) || (state_ff == S_HOLD)) && out_free;
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = cmd.load_out ? S_IDLE : S_HOLD;
         end
         S_HOLD: begin
            if (cmd.load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = (state_ff == S_IDLE);

   a_never_empty_and_full : assert property (@(posedge clock) disable iff (reset)
      !(stat.empty && stat.full))
      else $error("queue reported empty and full together");

   a_hold_means_result_waiting : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> rsp_valid_ff)
      else $error("holding a result while the output register is free");

   a_one_item_at_a_time : assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !cmd.accept)
      else $error("second item accepted before the first was finished");

   a_load_gives_valid : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("result loaded but not presented");

endmodule

// ===== rtl/core/array_double_ended_queue_unit.sv =====
// Top level of the array double-ended queue: controller plus datapath.
// Depends on adq_pkg, adq_ctrl, adq_datapath (and adq_ram below it).
//
// Usage: each request transfer carries one operation (push at head, pop
// from head, push at tail, pop from tail) and one value for pushes. Every
// request produces exactly one response transfer with a status code, the
// popped value (zero unless a pop succeeded) and the empty and full flags
// as they stand after the operation. The queue lives in a linear array
// that never wraps, so pushes can be refused while slots are free.
// The capacity register is written through its own valid/ready port and
// should only be changed while no request is in flight.
// Timing: a request is taken only while the controller is idle; at that edge
// the datapath registers the pending result and the slot RAM registers its
// read, and the response is loaded from them into the output register as soon
// as it is free. A new request is not taken until that load has happened.
// Stalling: while the receiver stalls, the response stays in the output
// register and a following request is still taken and executed; its
// result waits in the datapath until the output register is freed.
// Reset (synchronous, active high) marks both indices unused and sets the
// capacity to 64; the slot contents are not cleared and need no sweep.
module array_double_ended_queue_unit
   import adq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_opcode,
   input  logic signed [DATA_W-1:0] req_data_in,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data_out,
   output logic                     rsp_empty_flag,
   output logic                     rsp_full_flag,
   // capacity register write port
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAP_W-1:0]         csr_capacity
);

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences one operation at a time and owns the request
   // and response handshakes; the datapath only acts on its commands.
   adq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // A capacity transfer completes whenever valid meets ready.
   adq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .cfg_write    (csr_valid & csr_ready),
      .cfg_capacity (csr_capacity),
      .op_code      (req_opcode),
      .op_data      (req_data_in),
      .res_status   (rsp_status),
      .res_data     (rsp_data_out),
      .res_empty    (rsp_empty_flag),
      .res_full     (rsp_full_flag)
   );

endmodule

// ===== dv/adq_checker.sv =====
// Scoreboard for the array double-ended queue: watches the request, response
// and capacity channels, keeps its own copy of the queue and compares.
// Depends on adq_pkg for the opcode and status codes and the widths.
module adq_checker
   import adq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [DATA_W-1:0] req_data_in,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [2:0]        rsp_status,
   input  logic [DATA_W-1:0] rsp_data_out,
   input  logic              rsp_empty_flag,
   input  logic              rsp_full_flag,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_capacity,
   output int                fail_count
);

   typedef struct {
      status_type        status;
      logic [DATA_W-1:0] value;
      logic              empty;
      logic              full;
   } outcome_type;

   outcome_type       awaited_outcomes[$];
   logic [DATA_W-1:0] held_values [DEPTH];
   int                front_idx = -1;
   int                back_idx = -1;
   logic [CAP_W-1:0]  capacity_reg = CAP_RESET;
   int                mismatches = 0;
   int                waiting = 0;

   // Anything still awaited at the end counts against the run as well.
   assign fail_count = mismatches + waiting;

   // Out-of-range capacity values are clamped, the register keeps all bits.
   function automatic int slots_in_use();
      if (capacity_reg == '0) return 1;
      if (int'(capacity_reg) > DEPTH) return DEPTH;
      return int'(capacity_reg);
   endfunction

   function automatic logic deque_drained();
      return (front_idx == -1 && back_idx == -1) || front_idx > back_idx;
   endfunction

   function automatic logic deque_brimming();
      return front_idx == 0 && back_idx >= slots_in_use() - 1;
   endfunction

   // Applies one operation to the shadow queue and returns the response it owes.
   function automatic outcome_type advance_deque(opcode_type op, logic [DATA_W-1:0] value);
      outcome_type res;
      res.status = ST_OK;
      res.value  = '0;
      case (op)
         OP_PUSH_HEAD: begin
            if (deque_brimming()) begin
               res.status = ST_FULL;
            end else if (front_idx == -1) begin
               front_idx = 0;
               back_idx  = back_idx + 1;
               held_values[back_idx] = value;
            end else if (front_idx != 0) begin
               front_idx = front_idx - 1;
               held_values[front_idx] = value;
            end else begin
               res.status = ST_NO_HEAD;
            end
         end
         OP_POP_HEAD: begin
            if (deque_drained()) begin
               res.status = ST_EMPTY;
            end else begin
               res.value = held_values[front_idx];
               front_idx = front_idx + 1;
            end
         end
         OP_PUSH_TAIL: begin
            if (deque_brimming()) begin
               res.status = ST_FULL;
            end else if (back_idx >= slots_in_use() - 1) begin
               res.status = ST_NO_TAIL;
            end else begin
               if (front_idx == -1) front_idx = 0;
               back_idx = back_idx + 1;
               held_values[back_idx] = value;
            end
         end
         default: begin
            if (deque_drained()) begin
               res.status = ST_EMPTY;
            end else begin
               res.value = held_values[back_idx];
               back_idx  = back_idx - 1;
            end
         end
      endcase
      res.empty = deque_drained();
      res.full  = deque_brimming();
      return res;
   endfunction

   task automatic compare_field(string label, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         front_idx    = -1;
         back_idx     = -1;
         capacity_reg = CAP_RESET;
         awaited_outcomes.delete();
         waiting      = 0;
      end else begin
         // Responses are checked before this edge's request is predicted.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: response mismatch, expected none, actual status %0h data %0h",
                        $time, rsp_status, rsp_data_out);
            end else begin
               want    = awaited_outcomes.pop_front();
               waiting = waiting - 1;
               compare_field("status", DATA_W'(want.status), DATA_W'(rsp_status));
               compare_field("data_out", want.value, rsp_data_out);
               compare_field("empty_flag", DATA_W'(want.empty), DATA_W'(rsp_empty_flag));
               compare_field("full_flag", DATA_W'(want.full), DATA_W'(rsp_full_flag));
            end
         end
         if (req_valid && !req_stall) begin
            awaited_outcomes.push_back(advance_deque(opcode_type'(req_opcode), req_data_in));
            waiting = waiting + 1;
         end
         if (csr_valid && csr_ready) capacity_reg = csr_capacity;
      end
   end

endmodule

// ===== dv/array_double_ended_queue_unit_test.sv =====
// Top of the double-ended queue testbench: clock, reset, stimulus and verdict.
// Depends on adq_pkg, the array_double_ended_queue_unit RTL and adq_checker.
module array_double_ended_queue_unit_test;
   import adq_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 100;
   // Length of the deliberate receiver hold-off, in cycles.
   localparam int HOLD_CYCLES = 300;
   // The slowest legal run goes quiet for the hold-off plus a long gap; this
   // leaves several times that before the run is declared hung.
   localparam int QUIET_LIMIT = 2000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_opcode;
   logic signed [DATA_W-1:0] req_data_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [2:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic                     rsp_empty_flag;
   logic                     rsp_full_flag;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CAP_W-1:0]         csr_capacity;

   int fail_count;
   int issued;
   int retired;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit hold_rsp = 1'b0;

   array_double_ended_queue_unit #(.DEPTH(DEPTH)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_empty_flag (rsp_empty_flag),
      .rsp_full_flag  (rsp_full_flag),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity)
   );

   adq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_empty_flag (rsp_empty_flag),
      .rsp_full_flag  (rsp_full_flag),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity),
      .fail_count     (fail_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Requests in flight are counted here so that the stimulus knows when the
   // block is idle; each request transfer owes exactly one response transfer.
   always @(posedge clock) begin
      if (reset) begin
         issued  <= 0;
         retired <= 0;
      end else begin
         if (req_valid && !req_stall) issued <= issued + 1;
         if (rsp_valid && !rsp_stall) retired <= retired + 1;
      end
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   // Opcode mix: 0 is even, 1 leans towards pushes so that the array fills
   // to its ends, 2 leans towards pops so that it drains.
   function automatic opcode_type pick_op(int bias);
      int r;
      r = $urandom_range(0, 7);
      case (bias)
         1:       return (r < 6) ? ((r % 2) ? OP_PUSH_TAIL : OP_PUSH_HEAD)
                                 : ((r % 2) ? OP_POP_TAIL : OP_POP_HEAD);
         2:       return (r < 6) ? ((r % 2) ? OP_POP_TAIL : OP_POP_HEAD)
                                 : ((r % 2) ? OP_PUSH_TAIL : OP_PUSH_HEAD);
         default: return opcode_type'(r[1:0]);
      endcase
   endfunction

   // Values at the extremes of the signed range turn up now and then.
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Offers one request at the falling edge and holds it until the transfer.
   task automatic send_op(opcode_type op, logic [DATA_W-1:0] value);
      @(negedge clock);
      req_valid   = 1'b1;
      req_opcode  = op;
      req_data_in = value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic rest_req(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // The capacity is only changed once every response has come back.
   task automatic set_capacity(logic [CAP_W-1:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      while (issued != retired) @(negedge clock);
      csr_valid    = 1'b1;
      csr_capacity = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Receiver: runs of free flow alternate with runs of random stalls, and
   // once the stimulus asks, a long hold-off during which the sender keeps
   // offering, so that the block fills and stalls its input.
   initial begin : rsp_side
      int  run_left;
      int  stall_left;
      bit  calm;
      bit  held;
      rsp_stall  = 1'b0;
      run_left   = 0;
      stall_left = 0;
      calm       = 1'b0;
      held       = 1'b0;
      forever begin
         @(negedge clock);
         if (run_left == 0) begin
            calm     = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(20, 120);
         end
         run_left--;
         if (hold_rsp && !held) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            held      = 1'b1;
            rsp_stall = 1'b0;
         end else begin
            if (stall_left == 0 && !calm && $urandom_range(0, 2) == 0)
               stall_left = pause_len();
            rsp_stall = (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // The run is declared hung when no transfer of any kind happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [CAP_W-1:0] cap_plan [PHASES];
      bit               calm;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_opcode   = OP_PUSH_HEAD;
      req_data_in  = '0;
      csr_valid    = 1'b0;
      csr_capacity = CAP_RESET;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed part, starting from the reset capacity of 64. Popping an
      // untouched queue reports empty, and the very first head push lands
      // in slot zero.
      send_op(OP_POP_HEAD, $urandom);
      send_op(OP_PUSH_HEAD, 32'h8000_0000);
      // Draining from the tail leaves the head index at zero, so a head
      // push is refused for want of room although the queue is empty.
      send_op(OP_POP_TAIL, $urandom);
      send_op(OP_PUSH_HEAD, 32'h7fff_ffff);
      send_op(OP_POP_HEAD, $urandom);
      send_op(OP_POP_TAIL, $urandom);
      send_op(OP_PUSH_TAIL, 32'hffff_ffff);
      send_op(OP_PUSH_TAIL, 32'h0000_0000);
      send_op(OP_PUSH_TAIL, 32'h5555_5555);
      send_op(OP_PUSH_TAIL, 32'haaaa_aaaa);
      send_op(OP_POP_HEAD, $urandom);
      send_op(OP_PUSH_HEAD, 32'h1234_5678);
      send_op(OP_PUSH_HEAD, 32'h7fff_ffff);

      // Shrinking the capacity under four held items makes the queue full.
      set_capacity(7'd4);
      send_op(OP_PUSH_HEAD, $urandom);
      send_op(OP_PUSH_TAIL, $urandom);
      send_op(OP_POP_TAIL, $urandom);
      send_op(OP_PUSH_TAIL, 32'h7fff_ffff);

      // A tail push at the end is refused even with slot zero free.
      set_capacity(7'd2);
      send_op(OP_POP_HEAD, $urandom);
      send_op(OP_PUSH_TAIL, 32'h8000_0000);

      // A capacity of zero behaves as one, and one above the depth as the depth.
      set_capacity(7'd0);
      send_op(OP_PUSH_HEAD, $urandom);
      send_op(OP_POP_TAIL, $urandom);
      set_capacity(7'd127);
      send_op(OP_PUSH_TAIL, $urandom);
      send_op(OP_POP_HEAD, $urandom);

      // Random part: phases at different capacities, the extremes among them,
      // cycling through three opcode mixes. Small capacities reach full and
      // the refusal cases often; every fourth phase sends without gaps.
      cap_plan = '{7'd64, 7'd0, 7'd1, 7'd127, 7'd2, CAP_W'($urandom_range(3, 16)),
                   7'd5, CAP_W'($urandom_range(1, 127)), 7'd64};
      for (int phase = 0; phase < PHASES; phase++) begin
         set_capacity(cap_plan[phase]);
         calm = (phase % 4 == 3);
         if (phase == 4) hold_rsp = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_op(pick_op(phase % 3), pick_value());
            if (!calm && $urandom_range(0, 2) == 0) rest_req(pause_len());
         end
      end

      // Let every outstanding response come home, then a short settling time.
      @(negedge clock);
      req_valid = 1'b0;
      while (issued != retired) @(negedge clock);
      repeat (10) @(negedge clock);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
